FILE: src/slab_size_class_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// slab_size_class_allocator_unit_assert
// Assertion macros shared by the slab allocator unit.
// ----------------------------------------------------------------------------
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_UNIT_ASSERT_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SSCA_ASSERT_IMP(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define SSCA_ASSERT_NXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: src/ssca_pkg.sv
// ----------------------------------------------------------------------------
// ssca_pkg
// Constants, codes and helper functions of the slab size-class allocator.
// ----------------------------------------------------------------------------
package ssca_pkg;

	localparam logic [6:0] NIL = 7'd127;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_TOO_BIG  = 3'd2;
	localparam logic [2:0] ST_EXHAUST  = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// log2 of the object size of a class
	function automatic logic [3:0] class_shift(input logic [2:0] cls);
		return 4'(cls) + 4'd5;
	endfunction

endpackage

FILE: src/slab_size_class_allocator_unit.sv
// A rejected request completes straight after decode. A fresh slab has its object
// free list built first, up to 127 objects. A free that leaves a slab no longer full,
// or wholly free, walks the full or partial list to move it (128 entries at most).
// One request at a time: the next is taken the cycle after the result is accepted.
// arst_n clears control state, counters, list heads, pool use count and pool base page.
// ----------------------------------------------------------------------------
// slab_size_class_allocator_unit
// Slab allocator: size classes, partial/empty/full slab lists, LIFO objects.
// ----------------------------------------------------------------------------
`include "slab_size_class_allocator_unit_assert.svh"

module slab_size_class_allocator_unit #(
	parameter int POOL_PAGES   = 64,
	parameter int HEADER_BYTES = 24,
	parameter int CLASS_COUNT  = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [11:0] request_size,
	input  logic [31:0] object_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_address,
	output logic [2:0]  status,
	output logic [31:0] ok_total,
	output logic [31:0] free_total,
	output logic [31:0] fail_total
);
	import ssca_pkg::*;

	localparam logic [11:0] HDR = 12'((HEADER_BYTES + 7) & ~7);
	localparam logic [7:0]  NPAGES = 8'(POOL_PAGES);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_FILL  = 4'd2;
	localparam logic [3:0] S_ARD   = 4'd3;
	localparam logic [3:0] S_ARD2  = 4'd4;
	localparam logic [3:0] S_APOP  = 4'd5;
	localparam logic [3:0] S_FRD   = 4'd6;
	localparam logic [3:0] S_FDIV  = 4'd7;
	localparam logic [3:0] S_FPUSH = 4'd8;
	localparam logic [3:0] S_WALK  = 4'd9;
	localparam logic [3:0] S_WRD   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;
	localparam logic [3:0] S_EPOP  = 4'd12;

	logic [3:0]  state_q;
	logic [19:0] base_q;
	logic [7:0]  pages_q;
	logic [31:0] okc_q, frc_q, flc_q;
	logic [6:0]  full_h_q [8];
	logic [6:0]  part_h_q [8];
	logic [6:0]  empt_h_q [8];

	// per-slab memories (small, register arrays read at one address)
	logic [2:0]  sl_cls_m  [128];
	logic [6:0]  sl_fo_m   [128];
	logic [6:0]  sl_fh_m   [128];
	logic [6:0]  sl_lnk_m  [128];
	logic [6:0]  obj_m     [16384];

	// request / work registers
	logic        op_q;
	logic [11:0] size_q;
	logic [31:0] addr_q;
	logic [2:0]  cls_q;
	logic [6:0]  s_q, obj_q, cnt_q, total_q, prev_q, cur_q, fo_q, fh_q;
	logic [11:0] rem_q;
	logic [1:0]  which_q;   // 0 full list, 1 partial list
	logic [6:0]  objrd_q;
	logic [6:0]  lnkrd_q;
	logic [7:0]  steps_q;

	logic [31:0] res_addr_q;
	logic [2:0]  res_st_q;
	logic        out_valid_q;

	// APB
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {12'd0, base_q} : 32'd0;

	assign in_ready       = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid      = out_valid_q;
	assign result_address = res_addr_q;
	assign status         = res_st_q;
	assign ok_total       = okc_q;
	assign free_total     = frc_q;
	assign fail_total     = flc_q;

	// objects per slab: (4096-HDR)>>shift
	function automatic logic [6:0] objs(input logic [2:0] c);
		logic [11:0] avail;
		avail = 12'(13'd4096 - 13'(HDR));
		return 7'(avail >> class_shift(c));
	endfunction

	// smallest fitting class
	logic [2:0] cls_pick;
	always_comb begin
		cls_pick = 3'd7;
		priority if (size_q <= 12'd32) cls_pick = 3'd0;
		else if (size_q <= 12'd64)   cls_pick = 3'd1;
		else if (size_q <= 12'd128)  cls_pick = 3'd2;
		else if (size_q <= 12'd256)  cls_pick = 3'd3;
		else if (size_q <= 12'd512)  cls_pick = 3'd4;
		else if (size_q <= 12'd1024) cls_pick = 3'd5;
		else cls_pick = 3'd6;
	end

	logic [19:0] fpage;
	assign fpage = addr_q[31:12] - base_q;

	// slab link read address: empty head on decode, walk cursor, else current slab
	logic [6:0] lnk_ra;
	assign lnk_ra = (state_q == S_DEC) ? empt_h_q[cls_pick]
		: (state_q == S_WALK) ? cur_q : s_q;

	// object memory write port (a single write per cycle)
	logic        ow_en;
	logic [13:0] ow_a;
	logic [6:0]  ow_d;
	always_ff @(posedge clk) begin
		if (ow_en) obj_m[ow_a] <= ow_d;
		objrd_q <= obj_m[{s_q, fh_q}];
		lnkrd_q <= sl_lnk_m[lnk_ra];
	end

	always_comb begin
		ow_en = 1'b0;
		ow_a  = {s_q, cnt_q};
		ow_d  = (cnt_q + 7'd1 < total_q) ? cnt_q + 7'd1 : NIL;
		unique case (state_q)
			S_FILL: ow_en = 1'b1;
			S_FPUSH: begin
				ow_en = 1'b1;
				ow_a  = {s_q, obj_q};
				ow_d  = fh_q;
			end
			default: ow_en = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			pages_q     <= '0;
			okc_q       <= '0;
			frc_q       <= '0;
			flc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				full_h_q[i] <= NIL;
				part_h_q[i] <= NIL;
				empt_h_q[i] <= NIL;
			end
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0) base_q <= pwdata[19:0];
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q    <= opcode;
						size_q  <= request_size;
						addr_q  <= object_address;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_addr_q <= '0;
					res_st_q   <= ST_OK;
					if (op_q == OP_ALLOC) begin
						cls_q <= cls_pick;
						if (size_q == 12'd0) begin
							res_st_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else if (size_q > 12'd2048) begin
							res_st_q <= ST_TOO_BIG;
							state_q  <= S_DONE;
						end else if (32'(cls_pick) >= CLASS_COUNT) begin
							res_st_q <= ST_TOO_BIG;
							flc_q    <= flc_q + 32'd1;
							state_q  <= S_DONE;
						end else if (part_h_q[cls_pick] != NIL) begin
							s_q     <= part_h_q[cls_pick];
							state_q <= S_ARD;
						end else if (empt_h_q[cls_pick] != NIL) begin
							// move the empty head to the partial list; its old link
							// arrives in lnkrd_q for the next state
							s_q <= empt_h_q[cls_pick];
							sl_lnk_m[empt_h_q[cls_pick]] <= part_h_q[cls_pick];
							part_h_q[cls_pick] <= empt_h_q[cls_pick];
							state_q <= S_EPOP;
						end else if (pages_q >= NPAGES) begin
							res_st_q <= ST_EXHAUST;
							flc_q    <= flc_q + 32'd1;
							state_q  <= S_DONE;
						end else begin
							s_q     <= pages_q[6:0];
							pages_q <= 8'(pages_q[6:0] + 7'd1);
							sl_cls_m[pages_q[6:0]] <= cls_pick;
							sl_fo_m[pages_q[6:0]]  <= objs(cls_pick);
							sl_fh_m[pages_q[6:0]]  <= 7'd0;
							sl_lnk_m[pages_q[6:0]] <= part_h_q[cls_pick];
							part_h_q[cls_pick]     <= pages_q[6:0];
							total_q <= objs(cls_pick);
							cnt_q   <= 7'd0;
							state_q <= S_FILL;
						end
					end else begin
						res_st_q <= ST_IGNORED;
						if (addr_q == 32'd0) begin
							state_q <= S_DONE;
						end else begin
							frc_q <= frc_q + 32'd1;
							if (fpage >= 20'(pages_q)) state_q <= S_DONE;
							else begin
								s_q     <= fpage[6:0];
								state_q <= S_FRD;
							end
						end
					end
				end
				S_EPOP: begin
					// advance the empty list past the taken slab
					empt_h_q[cls_q] <= lnkrd_q;
					state_q         <= S_ARD;
				end
				S_FILL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q + 7'd1 >= total_q) state_q <= S_ARD;
				end
				S_ARD: begin
					fh_q    <= sl_fh_m[s_q];
					fo_q    <= sl_fo_m[s_q];
					state_q <= S_ARD2;
				end
				S_ARD2: state_q <= S_APOP;
				S_APOP: begin
					sl_fh_m[s_q] <= objrd_q;
					sl_fo_m[s_q] <= fo_q - 7'd1;
					if (fo_q - 7'd1 == 7'd0) begin
						part_h_q[cls_q] <= lnkrd_q;
						sl_lnk_m[s_q]   <= full_h_q[cls_q];
						full_h_q[cls_q] <= s_q;
					end
					okc_q      <= okc_q + 32'd1;
					res_addr_q <= ({12'd0, 20'(base_q + 20'(s_q))} << 12) + 32'(HDR)
						+ (32'(fh_q) << class_shift(cls_q));
					state_q    <= S_DONE;
				end
				S_FRD: begin
					cls_q   <= sl_cls_m[s_q];
					fh_q    <= sl_fh_m[s_q];
					fo_q    <= sl_fo_m[s_q];
					rem_q   <= addr_q[11:0] - HDR;
					state_q <= S_FDIV;
				end
				S_FDIV: begin
					// divide by class size: a shift and a mask
					total_q <= objs(cls_q);
					obj_q   <= 7'(rem_q >> class_shift(cls_q));
					if (32'(cls_q) >= CLASS_COUNT || addr_q[11:0] < HDR
						|| (rem_q & ((12'd1 << class_shift(cls_q)) - 12'd1)) != 12'd0
						|| (rem_q >> class_shift(cls_q)) >= 12'(objs(cls_q)))
						state_q <= S_DONE;
					else state_q <= S_FPUSH;
				end
				S_FPUSH: begin
					res_st_q     <= ST_OK;
					sl_fh_m[s_q] <= obj_q;
					sl_fo_m[s_q] <= fo_q + 7'd1;
					prev_q  <= NIL;
					steps_q <= '0;
					if (fo_q == 7'd0) begin
						which_q <= 2'd0;
						cur_q   <= full_h_q[cls_q];
						state_q <= S_WALK;
					end else if (fo_q + 7'd1 == total_q) begin
						which_q <= 2'd1;
						cur_q   <= part_h_q[cls_q];
						state_q <= S_WALK;
					end else state_q <= S_DONE;
				end
				S_WALK: begin
					if (cur_q == NIL || steps_q[7]) state_q <= S_DONE;
					else state_q <= S_WRD;
				end
				S_WRD: begin
					// one list entry per pass: lnkrd_q holds link of cur
					if (cur_q == s_q) begin
						if (prev_q == NIL) begin
							if (which_q == 2'd0) full_h_q[cls_q] <= lnkrd_q;
							else part_h_q[cls_q] <= lnkrd_q;
						end else sl_lnk_m[prev_q] <= lnkrd_q;
						state_q <= S_DONE;
						if (which_q == 2'd0) begin
							sl_lnk_m[s_q]   <= part_h_q[cls_q];
							part_h_q[cls_q] <= s_q;
						end else begin
							sl_lnk_m[s_q]   <= empt_h_q[cls_q];
							empt_h_q[cls_q] <= s_q;
						end
					end else begin
						prev_q  <= cur_q;
						cur_q   <= lnkrd_q;
						steps_q <= steps_q + 8'd1;
						state_q <= S_WALK;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SSCA_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == S_IDLE)
	`SSCA_ASSERT_NXT(a_done_out, clk, arst_n, state_q == S_DONE, out_valid)
	`SSCA_ASSERT_IMP(a_pages_max, clk, arst_n, 1'b1, pages_q <= NPAGES)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed alloc/free requests into the slab allocator,
// predicts every result with a behavioral copy of the allocator state and
// compares each result field by field in request order.
// ----------------------------------------------------------------------------
import ssca_pkg::*;

class slab_scoreboard;
	localparam int PAGES = 64;
	localparam int HDR = 24;
	localparam int NCLS = 7;

	logic [19:0] base_page;
	int unsigned pages_taken;
	logic [2:0] pg_class[128];
	logic [6:0] pg_free_cnt[128];
	logic [6:0] pg_free_head[128];
	logic [6:0] pg_link[128];
	logic [6:0] obj_next[16384];
	logic [6:0] full_head[8];
	logic [6:0] part_head[8];
	logic [6:0] empty_head[8];
	logic [31:0] n_ok, n_free, n_fail;
	int errors;

	typedef struct packed {
		logic [31:0] addr;
		logic [2:0] st;
		logic [31:0] ok, fr, fl;
	} slab_result_t;
	slab_result_t expected_q[$];
	// addresses handed out, for well-formed frees
	logic [31:0] live_addrs[$];

	function new();
		base_page = 0;
		pages_taken = 0;
		for (int i = 0; i < 8; i++) begin
			full_head[i] = NIL;
			part_head[i] = NIL;
			empty_head[i] = NIL;
		end
		n_ok = 0;
		n_free = 0;
		n_fail = 0;
		errors = 0;
	endfunction

	function int unsigned per_slab(int unsigned c);
		return (4096 - HDR) >> (c + 5);
	endfunction

	// remove slab s from a list; return 1 if found
	function bit unlink(ref logic [6:0] head, input logic [6:0] s);
		logic [6:0] prev, cur;
		prev = NIL;
		cur = head;
		for (int n = 0; n < 128 && cur != NIL; n++) begin
			if (cur == s) begin
				if (prev == NIL) head = pg_link[s];
				else pg_link[prev] = pg_link[s];
				return 1;
			end
			prev = cur;
			cur = pg_link[cur];
		end
		return 0;
	endfunction

	function void alloc_obj(logic [11:0] sz, output logic [31:0] a, output logic [2:0] st);
		int unsigned c, total;
		logic [6:0] s, o;
		a = 0;
		if (sz == 0) begin st = ST_ZERO; return; end
		if (sz > 2048) begin st = ST_TOO_BIG; return; end
		for (c = 0; c < NCLS; c++) if ((32 << c) >= sz) break;
		if (c >= NCLS) begin n_fail++; st = ST_TOO_BIG; return; end
		s = part_head[c];
		if (s == NIL) begin
			s = empty_head[c];
			if (s == NIL) begin
				total = per_slab(c);
				if (pages_taken >= PAGES) begin n_fail++; st = ST_EXHAUST; return; end
				s = pages_taken[6:0];
				pages_taken = (pages_taken + 1) & 127;
				pg_class[s] = c[2:0];
				pg_free_cnt[s] = total[6:0];
				pg_free_head[s] = 0;
				for (int unsigned i = 0; i < total; i++)
					obj_next[{s, i[6:0]}] = (i + 1 < total) ? 7'(i + 1) : NIL;
			end else begin
				empty_head[c] = pg_link[s];
			end
			pg_link[s] = part_head[c];
			part_head[c] = s;
		end
		o = pg_free_head[s];
		pg_free_head[s] = obj_next[{s, o}];
		pg_free_cnt[s] = pg_free_cnt[s] - 7'd1;
		if (pg_free_cnt[s] == 0) begin
			part_head[c] = pg_link[s];
			pg_link[s] = full_head[c];
			full_head[c] = s;
		end
		n_ok++;
		a = ({12'd0, base_page + 20'(s)} << 12) + HDR + (32'(o) << (c + 5));
		st = ST_OK;
		live_addrs.push_back(a);
	endfunction

	function logic [2:0] free_obj(logic [31:0] a);
		logic [19:0] p;
		int unsigned c, sz, total, off, o;
		logic [6:0] old, ps;
		if (a == 0) return ST_IGNORED;
		n_free++;
		p = a[31:12] - base_page;
		if (p >= pages_taken) return ST_IGNORED;
		ps = p[6:0];
		c = pg_class[ps];
		if (c >= NCLS) return ST_IGNORED;
		sz = 32 << c;
		total = per_slab(c);
		off = a[11:0];
		if (off < HDR || ((off - HDR) % sz) != 0) return ST_IGNORED;
		o = (off - HDR) / sz;
		if (o >= total) return ST_IGNORED;
		obj_next[{ps, o[6:0]}] = pg_free_head[ps];
		pg_free_head[ps] = o[6:0];
		old = pg_free_cnt[ps];
		pg_free_cnt[ps] = old + 7'd1;
		if (old == 0) begin
			if (unlink(full_head[c], ps)) begin
				pg_link[ps] = part_head[c];
				part_head[c] = ps;
			end
		end else if (pg_free_cnt[ps] == total) begin
			if (unlink(part_head[c], ps)) begin
				pg_link[ps] = empty_head[c];
				empty_head[c] = ps;
			end
		end
		return ST_OK;
	endfunction

	// note an accepted request and queue its expected result
	function void note_request(logic op, logic [11:0] sz, logic [31:0] a);
		slab_result_t r;
		if (op == OP_ALLOC) alloc_obj(sz, r.addr, r.st);
		else begin
			r.addr = 0;
			r.st = free_obj(a);
		end
		r.ok = n_ok;
		r.fr = n_free;
		r.fl = n_fail;
		expected_q.push_back(r);
	endfunction

	function void check_result(slab_result_t got);
		slab_result_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result, actual %h", $time, got);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (got.addr !== e.addr) begin
			$display("%0t: result_address expected %h actual %h", $time, e.addr, got.addr);
			errors++;
		end
		if (got.st !== e.st) begin
			$display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
			errors++;
		end
		if (got.ok !== e.ok) begin
			$display("%0t: ok_total expected %0d actual %0d", $time, e.ok, got.ok);
			errors++;
		end
		if (got.fr !== e.fr) begin
			$display("%0t: free_total expected %0d actual %0d", $time, e.fr, got.fr);
			errors++;
		end
		if (got.fl !== e.fl) begin
			$display("%0t: fail_total expected %0d actual %0d", $time, e.fl, got.fl);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, opcode;
	logic [11:0] request_size;
	logic [31:0] object_address;
	logic out_valid, out_ready;
	logic [31:0] result_address, ok_total, free_total, fail_total;
	logic [2:0] status;

	slab_scoreboard board;
	bit quiet_phase;
	int idle_cycles = 0;

	slab_size_class_allocator_unit uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall bursts, check every accepted result
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result({result_address, status, ok_total, free_total, fail_total});
			if (!quiet_phase && out_ready && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 9);
				out_ready <= 0;
				repeat (gap) @(posedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic cfg_write(logic [19:0] page);
		psel <= 1;
		pwrite <= 1;
		paddr <= 2'd0;
		pwdata <= {12'd0, page};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.base_page = page;
	endtask

	// hold valid from the last request into the next one; drop it only for idling
	task automatic send(logic op, logic [11:0] sz, logic [31:0] a);
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		request_size <= sz;
		object_address <= a;
		do @(posedge clk); while (!in_ready);
		board.note_request(op, sz, a);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic rand_item();
		int k;
		logic [31:0] a;
		k = $urandom_range(0, 99);
		if (k < 50) begin
			send(OP_ALLOC, (k < 40) ? 12'($urandom_range(1, 300)) : 12'($urandom_range(1, 2048)), 0);
		end else if (k < 85 && board.live_addrs.size() != 0) begin
			int idx;
			idx = $urandom_range(0, board.live_addrs.size() - 1);
			a = board.live_addrs[idx];
			board.live_addrs.delete(idx);
			send(OP_FREE, 12'($urandom), a);
		end else if (k < 92) begin
			send(OP_ALLOC, 12'($urandom), $urandom);
		end else begin
			// near-miss and random frees
			a = {board.base_page + 20'($urandom_range(0, 70)), 12'($urandom)};
			send(OP_FREE, 12'($urandom), ($urandom_range(0, 1)) ? a : $urandom);
		end
	endtask

	initial begin
		board = new();
		quiet_phase = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; opcode = 0; request_size = 0; object_address = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of every field and each special case
		cfg_write(20'hFFFFF);
		send(OP_ALLOC, 12'd0, 32'hFFFFFFFF);
		send(OP_ALLOC, 12'd4095, 0);
		send(OP_ALLOC, 12'd2049, 0);
		send(OP_ALLOC, 12'd2048, 0);
		send(OP_ALLOC, 12'd1, 0);
		send(OP_ALLOC, 12'd33, 0);
		send(OP_FREE, 12'd0, 32'h0);
		send(OP_FREE, 12'hFFF, 32'hFFFFFFFF);
		send(OP_FREE, 12'd0, 32'hFFFFF018);
		send(OP_FREE, 12'd0, 32'hFFFFF018);
		send(OP_FREE, 12'd0, 32'hFFFFF019);
		send(OP_FREE, 12'd0, 32'hFFFFF000);
		send(OP_FREE, 12'd0, 32'h00000818);
		send(OP_FREE, 12'd0, 32'h00000FF8);
		send(OP_ALLOC, 12'd2000, 0);
		send(OP_ALLOC, 12'd2000, 0);
		wait_drained();

		// exhaust the pool with 2 KiB objects
		cfg_write(20'd0);
		for (int i = 0; i < 140; i++) send(OP_ALLOC, 12'd2048, 0);
		wait_drained();

		// random phases at different pool bases; reset state stays
		for (int ph = 0; ph < 3; ph++) begin
			cfg_write((ph == 0) ? 20'h00000 : 20'($urandom));
			for (int i = 0; i < 500; i++) rand_item();
			wait_drained();
		end
		cfg_write(20'h12345);
		quiet_phase = 1;
		for (int i = 0; i < 150; i++) rand_item();
		wait_drained();

		if (board.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
